[src/psw_pkg.sv]
package psw_pkg;

  // input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_PLUCK = 1'b1;

  // reset values
  localparam logic [7:0] SAW_RESET_LEN = 8'd128;
  localparam logic [7:0] PERIOD_RESET  = 8'd255;
  localparam logic [3:0] DECAY_RESET   = 4'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FILL,
    ST_IDLE,
    ST_EMIT
  } psw_state_t;

  // a finished sample handed to the output register
  typedef struct packed {
    logic       load;
    logic [6:0] sample;
  } psw_emit_t;

  // half-amplitude sawtooth entry for a period of len
  function automatic logic [6:0] saw_value(input logic [7:0] idx, input logic [7:0] len);
    logic [8:0] up;
    up = {1'b0, idx} + 9'd256 - {1'b0, len};
    if (idx < (len >> 1)) begin
      return idx[7:1];
    end
    return up[7:1];
  endfunction

endpackage

[src/psw_in_if.sv]
interface psw_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] period_length;

  modport source(output valid, output kind, output period_length, input ready);
  modport sink(input valid, input kind, input period_length, output ready);
endinterface

[src/psw_out_if.sv]
interface psw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

[src/psw_table.sv]
module psw_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [6:0]    rdata_a,
  output logic [6:0]    rdata_b
);

  logic [6:0] mem_r [DEPTH];
  logic [6:0] rdata_a_r;
  logic [6:0] rdata_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[src/psw_ctrl.sv]
module psw_ctrl #(
  parameter int TABLE_DEPTH = 256,
  parameter int AW          = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  input  logic [7:0]          in_period,
  output logic                in_ready,
  input  logic [3:0]          decay_passes,
  input  logic                out_free,
  output psw_pkg::psw_emit_t  emit,
  output logic                tbl_we,
  output logic [AW-1:0]       tbl_waddr,
  output logic [6:0]          tbl_wdata,
  output logic                tbl_re,
  output logic [AW-1:0]       tbl_raddr_cur,
  output logic [AW-1:0]       tbl_raddr_prev,
  input  logic [6:0]          tbl_rdata_cur,
  input  logic [6:0]          tbl_rdata_prev
);
  import psw_pkg::*;

  localparam logic [AW-1:0] LAST_SLOT  = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] PREV_RESET = AW'(255 % TABLE_DEPTH);

  psw_state_t    state_r, state_nxt;
  logic [7:0]    read_pos_r, read_pos_nxt;
  logic [AW-1:0] cur_slot_r, cur_slot_nxt;
  logic [AW-1:0] prev_slot_r, prev_slot_nxt;
  logic [7:0]    period_r, period_nxt;
  logic [3:0]    pass_r, pass_nxt;
  logic [7:0]    fill_cnt_r, fill_cnt_nxt;
  logic [AW-1:0] fill_slot_r, fill_slot_nxt;
  logic [7:0]    fill_len_r, fill_len_nxt;

  logic          accept;
  logic          fill_last;
  logic          emit_go;
  logic [7:0]    pos_inc;

  assign accept    = in_valid && in_ready;
  assign fill_last = (fill_cnt_r == fill_len_r - 8'd1);
  assign emit_go   = (state_r == ST_EMIT) && out_free;
  assign pos_inc   = read_pos_r + 8'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (fill_slot_r == LAST_SLOT) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TICK) begin
            state_nxt = ST_EMIT;
          end else if (in_period != 8'd0) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake, table port, emitted sample
  always_comb begin
    in_ready       = 1'b0;
    tbl_we         = 1'b0;
    tbl_waddr      = fill_slot_r;
    tbl_wdata      = 7'd0;
    tbl_re         = 1'b0;
    tbl_raddr_cur  = cur_slot_r;
    tbl_raddr_prev = prev_slot_r;
    emit.load      = 1'b0;
    emit.sample    = tbl_rdata_cur;
    case (state_r)
      ST_CLEAR: begin
        tbl_we = 1'b1;
      end
      ST_FILL: begin
        tbl_we    = 1'b1;
        tbl_wdata = saw_value(fill_cnt_r, fill_len_r);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        tbl_re   = 1'b1;
      end
      ST_EMIT: begin
        emit.load = out_free;
        tbl_we    = out_free && (pass_r == 4'd0);
        tbl_waddr = cur_slot_r;
        tbl_wdata = {1'b0, tbl_rdata_cur[6:1]} + {1'b0, tbl_rdata_prev[6:1]};
      end
      default: ;
    endcase
  end

  // position, pass and fill bookkeeping
  always_comb begin
    read_pos_nxt  = read_pos_r;
    cur_slot_nxt  = cur_slot_r;
    prev_slot_nxt = prev_slot_r;
    period_nxt    = period_r;
    pass_nxt      = pass_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_slot_nxt = fill_slot_r;
    fill_len_nxt  = fill_len_r;

    // fill sweep walks the table with its own wrapping slot
    if (state_r == ST_CLEAR || state_r == ST_FILL) begin
      fill_cnt_nxt  = fill_cnt_r + 8'd1;
      fill_slot_nxt = (fill_slot_r == LAST_SLOT) ? '0 : fill_slot_r + AW'(1);
    end
    if (state_r == ST_CLEAR && fill_slot_r == LAST_SLOT) begin
      fill_cnt_nxt  = 8'd0;
      fill_slot_nxt = '0;
      fill_len_nxt  = SAW_RESET_LEN;
    end

    // pluck transaction
    if (accept && in_kind == KIND_PLUCK) begin
      period_nxt    = in_period;
      fill_len_nxt  = in_period;
      fill_cnt_nxt  = 8'd0;
      fill_slot_nxt = '0;
    end

    // tick retires: advance read position
    if (emit_go) begin
      prev_slot_nxt = cur_slot_r;
      if (pos_inc == period_r) begin
        read_pos_nxt = 8'd0;
        cur_slot_nxt = '0;
        pass_nxt     = (pass_r == decay_passes) ? 4'd0 : pass_r + 4'd1;
      end else begin
        read_pos_nxt = pos_inc;
        if (pos_inc == 8'd0 || cur_slot_r == LAST_SLOT) begin
          cur_slot_nxt = '0;
        end else begin
          cur_slot_nxt = cur_slot_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      read_pos_r  <= 8'd0;
      cur_slot_r  <= '0;
      prev_slot_r <= PREV_RESET;
      period_r    <= PERIOD_RESET;
      pass_r      <= 4'd0;
      fill_cnt_r  <= 8'd0;
      fill_slot_r <= '0;
      fill_len_r  <= SAW_RESET_LEN;
    end else begin
      state_r     <= state_nxt;
      read_pos_r  <= read_pos_nxt;
      cur_slot_r  <= cur_slot_nxt;
      prev_slot_r <= prev_slot_nxt;
      period_r    <= period_nxt;
      pass_r      <= pass_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_slot_r <= fill_slot_nxt;
      fill_len_r  <= fill_len_nxt;
    end
  end

endmodule

[src/plucked_string_wavetable_synth_unit.sv]
// tick: the accepting edge registers the table read; ST_EMIT, with input ready low,
//   waits for a free output register, then loads the sample and does the table write-back
// pluck of length L: the accepting cycle then one table entry written per cycle,
//   L entries in all; length 0 writes none
// reset: clearing pass over all TABLE_DEPTH slots, then a 128-entry sawtooth fill,
//   input ready stays low throughout; config writes are taken at any time
module plucked_string_wavetable_synth_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  psw_in_if.sink        in_chan,
  psw_out_if.source     out_chan,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_data
);
  import psw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [3:0]    decay_r;
  logic          out_valid_r;
  logic [6:0]    out_sample_r;
  logic          out_free;
  psw_emit_t     emit;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [6:0]    tbl_wdata;
  logic          tbl_re;
  logic [AW-1:0] tbl_raddr_cur;
  logic [AW-1:0] tbl_raddr_prev;
  logic [6:0]    tbl_rdata_cur;
  logic [6:0]    tbl_rdata_prev;

  // decay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
    end else if (cfg_we) begin
      decay_r <= cfg_data;
    end
  end

  // output register
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_sample_r <= emit.sample;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = out_sample_r;

  psw_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_chan.valid),
    .in_kind(in_chan.kind),
    .in_period(in_chan.period_length),
    .in_ready(in_chan.ready),
    .decay_passes(decay_r),
    .out_free(out_free),
    .emit(emit),
    .tbl_we(tbl_we),
    .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata),
    .tbl_re(tbl_re),
    .tbl_raddr_cur(tbl_raddr_cur),
    .tbl_raddr_prev(tbl_raddr_prev),
    .tbl_rdata_cur(tbl_rdata_cur),
    .tbl_rdata_prev(tbl_rdata_prev)
  );

  psw_table #(
    .DEPTH(TABLE_DEPTH),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .we(tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re(tbl_re),
    .raddr_a(tbl_raddr_cur),
    .raddr_b(tbl_raddr_prev),
    .rdata_a(tbl_rdata_cur),
    .rdata_b(tbl_rdata_prev)
  );

  // a tick transaction holds off the next input for its write-back cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.kind == KIND_TICK) |=> !in_chan.ready)
    else $error("input taken during tick write-back");

  // a nonzero pluck occupies the table port
  a_pluck_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.kind == KIND_PLUCK &&
     in_chan.period_length != 8'd0) |=> !in_chan.ready)
    else $error("input taken during table fill");

  // never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> (!out_valid_r || out_chan.ready))
    else $error("output register overwritten");

  // emitted sample shows up on the output
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |=> (out_chan.valid && out_chan.sample == $past(emit.sample)))
    else $error("emitted sample lost");

endmodule
